/* rtl/fstp_pkg.sv */
// ----------------------------------------------------------------------------
// fstp_pkg
// Shared types, codes and constant tables of the fuzzy self-tuning PI block.
// ----------------------------------------------------------------------------
package fstp_pkg;

  localparam int FracBits = 16;
  localparam int NumSets  = 7;

  localparam logic [23:0] KpReset      = 24'd543949;
  localparam logic [23:0] KiReset      = 24'd78643;
  localparam logic [15:0] SatBandReset = 16'd60;
  localparam logic [15:0] OvsBandReset = 16'd8;
  localparam logic [15:0] DeadReset    = 16'd0;
  localparam logic [15:0] DriveMaxReset = 16'd7200;

  localparam logic [2:0] RowLast = 3'(NumSets - 1);

  typedef enum logic [2:0] {
    REG_KP_INITIAL,
    REG_KI_INITIAL,
    REG_SATURATE_BAND,
    REG_OVERSHOOT_BAND,
    REG_DEAD_BAND,
    REG_DRIVE_MAX
  } reg_idx_e;

  typedef enum logic [1:0] {
    SHAPE_L,
    SHAPE_T,
    SHAPE_R
  } shape_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEMB,
    ST_ROW,
    ST_DIVP,
    ST_GAINP,
    ST_DIVI,
    ST_GAINI,
    ST_MULP,
    ST_MULI,
    ST_SCALE,
    ST_DIVS,
    ST_UPD
  } state_e;

  // Fuzzy set outlines in set units: shape, left foot, peak, right foot
  localparam shape_e SetShape [NumSets] = '{SHAPE_L, SHAPE_T, SHAPE_T, SHAPE_T,
                                            SHAPE_T, SHAPE_T, SHAPE_R};
  localparam int SetA [NumSets] = '{-3, -3, -3, -2, -1, 0, 1};
  localparam int SetB [NumSets] = '{-1, -2, -1, 0, 1, 2, 3};
  localparam int SetC [NumSets] = '{0, 0, 1, 2, 3, 3, 0};

  // Twice the centroid at strength mu: C0*one + C1*mu
  localparam int DefC0 [NumSets] = '{-2, -3, -2, 0, 2, 3, 2};
  localparam int DefC1 [NumSets] = '{-4, -1, 0, 0, 0, 1, 4};

  localparam logic [2:0] RuleP [NumSets][NumSets] = '{
    '{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3},
    '{3'd6, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd3},
    '{3'd5, 3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd2},
    '{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1},
    '{3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1},
    '{3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0},
    '{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0}
  };

  localparam logic [2:0] RuleI [NumSets][NumSets] = '{
    '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3},
    '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3},
    '{3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5},
    '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6},
    '{3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6},
    '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6}
  };

  typedef struct packed {
    logic       capture;
    logic       memb;
    logic       row;
    logic [2:0] row_idx;
    logic       div_p;
    logic       gain_p;
    logic       div_i;
    logic       gain_i;
    logic       mul_p;
    logic       mul_i;
    logic       scale;
    logic       div_s;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [23:0] kp_initial;
    logic [23:0] ki_initial;
    logic [15:0] saturate_band;
    logic [15:0] overshoot_band;
    logic [15:0] dead_band;
    logic [15:0] drive_max;
    logic        kp_load;
    logic        ki_load;
  } cfg_t;

endpackage

/* rtl/fstp_if.sv */
// ----------------------------------------------------------------------------
// fstp_in_if / fstp_out_if
// Valid/ready channels for samples in and drive results out.
// ----------------------------------------------------------------------------
interface fstp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] setpoint;
  logic [15:0] measured;
  modport source (output valid, output setpoint, output measured, input ready);
  modport sink (input valid, input setpoint, input measured, output ready);
endinterface

interface fstp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive_level;
  logic        gains_tuned;
  modport source (output valid, output drive_level, output gains_tuned, input ready);
  modport sink (input valid, input drive_level, input gains_tuned, output ready);
endinterface

/* rtl/fstp_regs.sv */
// ----------------------------------------------------------------------------
// fstp_regs
// APB register file; flags a reload of the running gains after a write to kp_initial or ki_initial.
// ----------------------------------------------------------------------------
module fstp_regs import fstp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic        wr;
  reg_idx_e    idx;
  logic [23:0] kp_q, ki_q;
  logic [15:0] sat_q, ovs_q, dead_q, dmax_q;
  logic        kp_load_q, ki_load_q;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= KpReset;
      ki_q      <= KiReset;
      sat_q     <= SatBandReset;
      ovs_q     <= OvsBandReset;
      dead_q    <= DeadReset;
      dmax_q    <= DriveMaxReset;
      kp_load_q <= 1'b0;
      ki_load_q <= 1'b0;
    end else begin
      kp_load_q <= 1'b0;
      ki_load_q <= 1'b0;
      if (wr) begin
        case (idx)
          REG_KP_INITIAL: begin
            kp_q      <= pwdata[23:0];
            kp_load_q <= 1'b1;
          end
          REG_KI_INITIAL: begin
            ki_q      <= pwdata[23:0];
            ki_load_q <= 1'b1;
          end
          REG_SATURATE_BAND:  sat_q  <= pwdata[15:0];
          REG_OVERSHOOT_BAND: ovs_q  <= pwdata[15:0];
          REG_DEAD_BAND:      dead_q <= pwdata[15:0];
          REG_DRIVE_MAX:      dmax_q <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_KP_INITIAL:     prdata = {8'd0, kp_q};
      REG_KI_INITIAL:     prdata = {8'd0, ki_q};
      REG_SATURATE_BAND:  prdata = {16'd0, sat_q};
      REG_OVERSHOOT_BAND: prdata = {16'd0, ovs_q};
      REG_DEAD_BAND:      prdata = {16'd0, dead_q};
      REG_DRIVE_MAX:      prdata = {16'd0, dmax_q};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{kp_initial: kp_q, ki_initial: ki_q, saturate_band: sat_q,
                   overshoot_band: ovs_q, dead_band: dead_q, drive_max: dmax_q,
                   kp_load: kp_load_q, ki_load: ki_load_q};

endmodule

/* rtl/fstp_ctrl.sv */
// ----------------------------------------------------------------------------
// fstp_ctrl
// Sequencer: steps one sample through fuzzify, rule search, tuning and PI step.
// ----------------------------------------------------------------------------
module fstp_ctrl import fstp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [2:0] row_q, row_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    cmd_o         = '0;
    cmd_o.row_idx = row_q;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MEMB;
        end
      end
      ST_MEMB: begin
        cmd_o.memb = 1'b1;
        row_d      = 3'd0;
        state_d    = ST_ROW;
      end
      ST_ROW: begin
        cmd_o.row = 1'b1;
        if (row_q == RowLast) begin
          state_d = ST_DIVP;
        end else begin
          row_d = row_q + 3'd1;
        end
      end
      ST_DIVP: begin
        cmd_o.div_p = 1'b1;
        state_d     = ST_GAINP;
      end
      ST_GAINP: begin
        cmd_o.gain_p = 1'b1;
        state_d      = ST_DIVI;
      end
      ST_DIVI: begin
        cmd_o.div_i = 1'b1;
        state_d     = ST_GAINI;
      end
      ST_GAINI: begin
        cmd_o.gain_i = 1'b1;
        state_d      = ST_MULP;
      end
      ST_MULP: begin
        cmd_o.mul_p = 1'b1;
        state_d     = ST_MULI;
      end
      ST_MULI: begin
        cmd_o.mul_i = 1'b1;
        state_d     = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_DIVS;
      end
      ST_DIVS: begin
        cmd_o.div_s = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* rtl/fstp_dp.sv */
// ----------------------------------------------------------------------------
// fstp_dp
// Datapath: error forming, memberships, rule search, gain tuning, PI step and
// the result register.
// ----------------------------------------------------------------------------
module fstp_dp import fstp_pkg::*; #(
  parameter int FRAC_BITS = FracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  cfg_t        cfg_i,
  input  logic [15:0] setpoint_i,
  input  logic [15:0] measured_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [15:0] drive_level_o,
  output logic        gains_tuned_o
);

  localparam int MW    = FRAC_BITS + 1;
  localparam int TW    = FRAC_BITS + 8;
  localparam int NW    = 31;
  localparam int QW    = 29;
  localparam int PW    = 52;
  localparam int DivSh = 36;

  localparam logic [33:0] Recip5  = 34'(((64'd1 << DivSh) + 64'd4) / 64'd5);
  localparam logic [33:0] Recip25 = 34'(((64'd1 << DivSh) + 64'd24) / 64'd25);
  localparam logic signed [33:0] OffP = 34'(5) << FRAC_BITS;
  localparam logic signed [33:0] OffI = 34'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] Lim = PW'(500) << FRAC_BITS;
  localparam logic [MW-1:0] MuOne = {1'b1, {FRAC_BITS{1'b0}}};

  typedef logic [MW-1:0] mu_t;
  typedef logic [FRAC_BITS+3:0] mu5_tbl_t [41];

  function automatic mu5_tbl_t build_mu5();
    mu5_tbl_t tbl;
    for (int k = 0; k < 41; k++) begin
      tbl[k] = (FRAC_BITS + 4)'((64'(k) << FRAC_BITS) / 64'd5);
    end
    return tbl;
  endfunction

  localparam mu5_tbl_t Mu5 = build_mu5();

  // t / span in QF for span of 10, 20 or 40
  function automatic mu_t frac(input logic [5:0] t, input int span);
    mu_t r;
    case (span)
      10:      r = mu_t'(Mu5[t] >> 1);
      20:      r = mu_t'(Mu5[t] >> 2);
      default: r = mu_t'(Mu5[t] >> 3);
    endcase
    return r;
  endfunction

  function automatic mu_t member(input int s, input logic signed [19:0] x, input int d);
    logic signed [19:0] a, b, c;
    mu_t mu;
    a  = 20'(SetA[s] * d);
    b  = 20'(SetB[s] * d);
    c  = 20'(SetC[s] * d);
    mu = '0;
    case (SetShape[s])
      SHAPE_L: begin
        if (x <= a) mu = MuOne;
        else if (x <= b) mu = frac(6'(b - x), (SetB[s] - SetA[s]) * d);
      end
      SHAPE_R: begin
        if (x <= a) mu = '0;
        else if (x < b) mu = frac(6'(x - a), (SetB[s] - SetA[s]) * d);
        else mu = MuOne;
      end
      default: begin
        if (x <= a) mu = '0;
        else if (x <= b) mu = frac(6'(x - a), (SetB[s] - SetA[s]) * d);
        else if (x <= c) mu = frac(6'(c - x), (SetC[s] - SetB[s]) * d);
      end
    endcase
    return mu;
  endfunction

  function automatic logic [31:0] gain_step(input logic [31:0] g, input logic [QW-1:0] q,
                                            input logic signed [33:0] off);
    logic signed [34:0] s;
    logic [31:0] r;
    s = signed'({3'b0, g}) + signed'({6'b0, q}) - 35'(off);
    if (s < 0) r = 32'd0;
    else if (s > 35'sh0FFFFFFFF) r = 32'hFFFF_FFFF;
    else r = s[31:0];
    return r;
  endfunction

  // state
  logic signed [16:0] e_q, le_q;
  logic signed [17:0] ec_q;
  mu_t                me_q [NumSets];
  mu_t                mc_q [NumSets];
  mu_t                best_q, best_n;
  logic [2:0]         bi_q, bj_q, bi_n, bj_n;
  logic [31:0]        prop_q, integ_q, acc_q;
  logic               armed_q, armed_n;
  logic [QW-1:0]      quot_q;
  logic signed [PW-1:0] psum_q;
  logic [NW-1:0]      ns_q;
  logic               sat_pos_q, sat_neg_q;
  logic               out_valid_q;
  logic [15:0]        drive_q;
  logic               tuned_q;

  // combinational
  logic signed [16:0] e_in;
  logic signed [19:0] e_x, ec_x, ec3_x;
  mu_t                me_d [NumSets];
  mu_t                mc_d [NumSets];
  logic [2:0]         rule_set;
  logic signed [TW-1:0] c0, c1, best_s, c1_term, t_val, t_off;
  logic [NW-1:0]      n_g, div_n;
  logic [33:0]        div_m;
  logic [64:0]        div_prod;
  logic [32:0]        mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [FRAC_BITS+10:0] pv;
  logic signed [FRAC_BITS+15:0] pq, q18;
  logic signed [FRAC_BITS+31:0] pa;
  logic signed [NW-1:0] v;
  logic signed [31:0] ns_d;
  logic signed [17:0] e18, mag, sb18, ob18, db18;
  logic               tuned;
  logic signed [33:0] top34, inc, acc_n;
  logic [31:0]        acc_new;

  assign e_in  = signed'({1'b0, setpoint_i}) - signed'({1'b0, measured_i});
  assign e_x   = 20'(e_q);
  assign ec_x  = 20'(ec_q);
  assign ec3_x = (ec_x <<< 1) + ec_x;

  always_comb begin
    for (int s = 0; s < NumSets; s++) begin
      me_d[s] = member(s, e_x, 20);
      mc_d[s] = member(s, ec3_x, 10);
    end
  end

  // one row of the rule grid; first strictly stronger rule wins
  always_comb begin
    mu_t w;
    mu_t rm;
    best_n = best_q;
    bi_n   = bi_q;
    bj_n   = bj_q;
    rm     = me_q[cmd_i.row_idx];
    for (int j = 0; j < NumSets; j++) begin
      w = (rm < mc_q[j]) ? rm : mc_q[j];
      if (w > best_n) begin
        best_n = w;
        bi_n   = cmd_i.row_idx;
        bj_n   = 3'(j);
      end
    end
  end

  // defuzzify the winning rule's correction set, offset to keep it positive
  assign rule_set = cmd_i.div_i ? RuleI[bi_q][bj_q] : RuleP[bi_q][bj_q];
  assign c0       = TW'(DefC0[rule_set]);
  assign c1       = TW'(DefC1[rule_set]);
  assign best_s   = signed'(TW'(best_q));

  // the slope is 0, +-1 or +-4: select a shifted copy of the strength
  always_comb begin
    case (c1)
      TW'(4):  c1_term = best_s <<< 2;
      TW'(-4): c1_term = -(best_s <<< 2);
      TW'(1):  c1_term = best_s;
      TW'(-1): c1_term = -best_s;
      default: c1_term = '0;
    endcase
  end

  assign t_val    = (c0 <<< FRAC_BITS) + c1_term;
  assign t_off    = t_val + (TW'(100) <<< FRAC_BITS);
  assign n_g      = NW'(unsigned'(t_off) >> 2);

  // shared divide-by-constant: reciprocal multiply, exact for n below 2^31
  assign div_n    = cmd_i.div_s ? ns_q : n_g;
  assign div_m    = cmd_i.div_i ? Recip25 : Recip5;
  assign div_prod = 65'(div_n) * 65'(div_m);

  // shared gain multiplier
  assign mul_a = cmd_i.mul_i ? {1'b0, integ_q} : {1'b0, prop_q};
  assign mul_b = cmd_i.mul_i ? 18'(e_q) : ec_q;
  assign mul_p = 51'(signed'(mul_a)) * 51'(mul_b);

  // scale the PI sum to drive units, times 18 here and floored by 5 in the divider
  assign pv   = psum_q[FRAC_BITS+10:0];
  assign pq   = (FRAC_BITS + 16)'(pv);
  assign q18  = (pq <<< 4) + (pq <<< 1);
  assign pa   = {q18, 16'd0};
  assign v    = pa[FRAC_BITS +: NW];
  assign ns_d = 32'(v) + 32'sd671088640;

  // band decisions
  assign e18   = 18'(e_q);
  assign mag   = (e18 < 0) ? -e18 : e18;
  assign sb18  = signed'({2'b0, cfg_i.saturate_band});
  assign ob18  = signed'({2'b0, cfg_i.overshoot_band});
  assign db18  = signed'({2'b0, cfg_i.dead_band});
  assign tuned = (mag <= sb18);
  assign top34 = signed'({2'b0, cfg_i.drive_max, 16'd0});

  always_comb begin
    logic signed [33:0] step;
    logic signed [33:0] base;
    armed_n = armed_q;
    inc     = '0;
    base    = signed'({2'b0, acc_q});
    if (sat_pos_q) step = 34'sd117964800;
    else if (sat_neg_q) step = -34'sd117964800;
    else step = signed'(34'(quot_q)) - 34'sd134217728;
    if (e18 > sb18) begin
      base    = top34;
      armed_n = 1'b1;
    end else if (e18 < -sb18) begin
      base = '0;
    end else if (mag < db18) begin
      inc = '0;
    end else if ((e18 < ob18) && armed_q) begin
      base    = '0;
      armed_n = 1'b0;
    end else if (-e18 > ob18) begin
      inc = -34'sd23592960;
    end else begin
      inc = step;
    end
    acc_n = base + inc;
    if (acc_n > top34) acc_new = top34[31:0];
    else if (acc_n < 0) acc_new = 32'd0;
    else acc_new = acc_n[31:0];
  end

  assign sts_o.out_free = !out_valid_q || res_ready_i;

  // running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q        <= '0;
      prop_q      <= 32'(KpReset);
      integ_q     <= 32'(KiReset);
      acc_q       <= '0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.kp_load) prop_q <= 32'(cfg_i.kp_initial);
      else if (cmd_i.gain_p && tuned) prop_q <= gain_step(prop_q, quot_q, OffP);
      if (cfg_i.ki_load) integ_q <= 32'(cfg_i.ki_initial);
      else if (cmd_i.gain_i && tuned) integ_q <= gain_step(integ_q, quot_q, OffI);
      if (cmd_i.commit) begin
        le_q        <= e_q;
        acc_q       <= acc_new;
        armed_q     <= armed_n;
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      e_q  <= e_in;
      ec_q <= 18'(e_in) - 18'(le_q);
    end
    if (cmd_i.memb) begin
      me_q   <= me_d;
      mc_q   <= mc_d;
      best_q <= '0;
      bi_q   <= 3'd0;
      bj_q   <= 3'd0;
    end
    if (cmd_i.row) begin
      best_q <= best_n;
      bi_q   <= bi_n;
      bj_q   <= bj_n;
    end
    if (cmd_i.div_p || cmd_i.div_i || cmd_i.div_s) quot_q <= div_prod[DivSh +: QW];
    if (cmd_i.mul_p) psum_q <= PW'(mul_p);
    if (cmd_i.mul_i) psum_q <= psum_q + PW'(mul_p);
    if (cmd_i.scale) begin
      sat_pos_q <= (psum_q >= Lim);
      sat_neg_q <= (psum_q <= -Lim);
      ns_q      <= ns_d[NW-1:0];
    end
    if (cmd_i.commit) begin
      drive_q <= acc_new[31:16];
      tuned_q <= tuned;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign drive_level_o = drive_q;
  assign gains_tuned_o = tuned_q;

endmodule

/* rtl/fuzzy_self_tuning_pid.sv */
// ----------------------------------------------------------------------------
// fuzzy_self_tuning_pid
// Fuzzy self-tuning incremental PI controller with an APB register port.
// ----------------------------------------------------------------------------
// Each accepted sample (setpoint, measured, in hundredths) yields one result:
// the new drive level and a flag telling whether the gains were retuned. The
// block holds one sample at a time, and the next sample can be taken in the
// same cycle as the result of the last one appears. The sequencer steps each
// sample through the fourteen memberships at once, a walk over the seven rows
// of the rule grid a row at a time, two passes through the shared reciprocal
// divider each followed by a gain step, two passes through the shared gain
// multiplier, a scaling step, a third divider pass and the drive update. The
// result sits in an output register, so a slow consumer stalls only the final
// step of the following sample. Write the configuration only while idle;
// writing kp_initial or ki_initial reloads the running gain.
// ----------------------------------------------------------------------------
module fuzzy_self_tuning_pid import fstp_pkg::*; #(
  parameter int FRAC_BITS = FracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fstp_in_if.sink     item_i,
  fstp_out_if.source  result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  fstp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: one sample in flight, transfer in only when idle
  fstp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and the result register
  fstp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg),
    .setpoint_i    (item_i.setpoint),
    .measured_i    (item_i.measured),
    .res_valid_o   (result_o.valid),
    .res_ready_i   (result_o.ready),
    .drive_level_o (result_o.drive_level),
    .gains_tuned_o (result_o.gains_tuned)
  );

endmodule

/* rtl/fstp_checker.sv */
// ----------------------------------------------------------------------------
// fstp_checker
// Port-level checks of the controller's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module fstp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] drive_level_i,
  input logic        gains_tuned_i
);

  // hold a pending result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(drive_level_i) && $stable(gains_tuned_i))
    else $error("result changed while stalled");

  // one sample at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second transfer taken while busy");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result raised straight after a transfer");

endmodule

bind fuzzy_self_tuning_pid fstp_checker u_fstp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .drive_level_i (result_o.drive_level),
  .gains_tuned_i (result_o.gains_tuned)
);
